### rtl/binary_heap_priority_queue_macros.svh
// Assertion helpers for the heap queue checker.
// Each expects signals named clk and rst_n in the calling scope.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BHPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define BHPQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bhpq_pkg.sv
package bhpq_pkg;

    localparam int CAPACITY      = 128;
    localparam int VALUE_WIDTH   = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int CHILD_W       = COUNT_W + 1;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 8;

    // Operation codes
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // take an input beat, issue root/last reads
        logic ext_latch;  // capture root and last entry
        logic su_issue;   // sift-up: read parent or finish at root
        logic su_step;    // sift-up: compare and write
        logic sd_issue;   // sift-down: read children or finish at leaf
        logic sd_step;    // sift-down: compare and write
        logic publish;    // load the result register
    } bhpq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic leaf;
        logic su_move;
        logic sd_move;
        logic out_free;
    } bhpq_stat_t;

    // True when a belongs strictly above b: smaller in min mode, larger in max mode.
    function automatic logic bhpq_above(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b,
        input logic                          max_mode
    );
        logic res;
        res = max_mode ? (a > b) : (a < b);
        return res;
    endfunction

endpackage

### rtl/bhpq_if.sv
interface bhpq_in_if import bhpq_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bhpq_out_if import bhpq_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic signed [VALUE_WIDTH-1:0]   removed_value;
    logic        [STATUS_W-1:0]      status;
    logic        [ENTRY_COUNT_W-1:0] entry_count;

    modport source (output valid, output removed_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input entry_count,
                    output ready);
endinterface

### rtl/binary_heap_priority_queue.sv
// Binary heap priority queue of signed 32-bit values, up to 128 entries, kept
// in a single RAM with one write and two registered read ports. cfg_wr_data
// selects the ordering (0: smallest at the root, 1: largest) and may only be
// written while the queue is idle; stored entries are not reordered when it
// changes. Each input beat is an insert (kind 0) or an extract (kind 1) and
// yields exactly one result beat carrying the removed root (zero unless an
// extract succeeded), a status (ok, full, empty) and the entry count after
// the operation. One operation runs at a time. After the accepting cycle, an
// insert repeats a parent read and a compare-and-write for each level that
// it climbs; an extract first latches the root and the last entry, then
// repeats a child read and a compare-and-write for each level that it
// descends. Each stops at the root or a leaf, or where the value no longer
// moves, and ends in a done state that loads the result register; a rejected
// operation goes there straight from the accepting cycle. The next beat is
// taken on the cycle after the result register is loaded. The result sits
// in an output register, so the next beat is taken while an earlier result
// waits for the sink; an operation that finishes while that register is
// still occupied holds in its done state until the sink takes the older
// beat.
module binary_heap_priority_queue import bhpq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    bhpq_in_if.sink     in_ch,
    bhpq_out_if.source  out_ch
);

    bhpq_cmd_t  cmd;
    bhpq_stat_t stat;

    // Sequencer: walks the sift loop one level per read/compare pair
    bhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Heap store, count, sift registers and the result register
    bhpq_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_kind           (in_ch.kind),
        .in_value          (in_ch.value),
        .out_ready         (out_ch.ready),
        .out_valid         (out_ch.valid),
        .out_removed_value (out_ch.removed_value),
        .out_status        (out_ch.status),
        .out_entry_count   (out_ch.entry_count),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule

### rtl/bhpq_ram.sv
module bhpq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [DATA_W-1:0]        rdata0,
    output logic [DATA_W-1:0]        rdata1
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

### rtl/bhpq_ctrl.sv
module bhpq_ctrl import bhpq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_kind,
    output logic       in_ready,
    input  bhpq_stat_t stat,
    output bhpq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXT_RD,
        S_INS_RD,
        S_INS_CMP,
        S_SD_RD,
        S_SD_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_kind == KIND_INSERT)
                    begin
                        state_next = stat.full ? S_DONE : S_INS_RD;
                    end
                    else
                    begin
                        state_next = stat.empty ? S_DONE : S_EXT_RD;
                    end
                end
            end
            S_EXT_RD:
            begin
                cmd.ext_latch = 1'b1;
                state_next    = S_SD_RD;
            end
            S_INS_RD:
            begin
                cmd.su_issue = 1'b1;
                state_next   = stat.idx_zero ? S_DONE : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                cmd.su_step = 1'b1;
                state_next  = stat.su_move ? S_INS_RD : S_DONE;
            end
            S_SD_RD:
            begin
                cmd.sd_issue = 1'b1;
                state_next   = stat.leaf ? S_DONE : S_SD_CMP;
            end
            S_SD_CMP:
            begin
                cmd.sd_step = 1'b1;
                state_next  = stat.sd_move ? S_SD_RD : S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register can take the beat
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bhpq_dp.sv
module bhpq_dp import bhpq_pkg::*; (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            in_kind,
    input  logic signed [VALUE_WIDTH-1:0]   in_value,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic signed [VALUE_WIDTH-1:0]   out_removed_value,
    output logic        [STATUS_W-1:0]      out_status,
    output logic        [ENTRY_COUNT_W-1:0] out_entry_count,
    input  bhpq_cmd_t                       cmd,
    output bhpq_stat_t                      stat
);

    logic                   order_mode_reg, order_mode_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] root_reg, root_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_removed_reg, out_removed_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr0, ram_raddr1;
    logic [VALUE_WIDTH-1:0] ram_rdata0, ram_rdata1;

    logic [ADDR_W-1:0]      parent_idx;
    logic [CHILD_W-1:0]     left_idx, right_idx;
    logic                   right_ok, take_right;
    logic [VALUE_WIDTH-1:0] child_val;
    logic [ADDR_W-1:0]      child_idx;
    logic                   full, empty, leaf, su_move, sd_move;

    bhpq_ram #(
        .DATA_W (VALUE_WIDTH),
        .DEPTH  (CAPACITY)
    ) u_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    // Tree navigation and compares
    always_comb
    begin
        full       = (count_reg == COUNT_W'(CAPACITY));
        empty      = (count_reg == '0);
        parent_idx = (idx_reg - ADDR_W'(1)) >> 1;
        left_idx   = (CHILD_W'(idx_reg) << 1) + CHILD_W'(1);
        right_idx  = left_idx + CHILD_W'(1);
        leaf       = (left_idx >= CHILD_W'(count_reg));
        right_ok   = (right_idx < CHILD_W'(count_reg));
        take_right = right_ok && bhpq_above(ram_rdata1, ram_rdata0, order_mode_reg);
        child_val  = take_right ? ram_rdata1 : ram_rdata0;
        child_idx  = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        sd_move    = take_right ? bhpq_above(ram_rdata1, val_reg, order_mode_reg)
                                : bhpq_above(ram_rdata0, val_reg, order_mode_reg);
        su_move    = bhpq_above(val_reg, ram_rdata0, order_mode_reg);
    end

    always_comb
    begin
        stat.full     = full;
        stat.empty    = empty;
        stat.idx_zero = (idx_reg == '0);
        stat.leaf     = leaf;
        stat.su_move  = su_move;
        stat.sd_move  = sd_move;
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Memory ports
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = val_reg;
        ram_raddr0 = '0;
        ram_raddr1 = '0;
        if (cmd.accept)
        begin
            ram_raddr1 = ADDR_W'(count_reg - COUNT_W'(1));
        end
        if (cmd.su_issue)
        begin
            ram_raddr0 = parent_idx;
            ram_we     = stat.idx_zero;
        end
        if (cmd.su_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = su_move ? ram_rdata0 : val_reg;
        end
        if (cmd.sd_issue)
        begin
            ram_raddr0 = left_idx[ADDR_W-1:0];
            ram_raddr1 = right_idx[ADDR_W-1:0];
            ram_we     = leaf;
        end
        if (cmd.sd_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = sd_move ? child_val : val_reg;
        end
    end

    // Next-state values
    always_comb
    begin
        order_mode_next  = cfg_wr_en ? cfg_wr_data : order_mode_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        val_next         = val_reg;
        root_next        = root_reg;
        status_next      = status_reg;
        out_removed_next = out_removed_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cmd.accept)
        begin
            val_next    = in_value;
            root_next   = '0;
            status_next = ST_OK;
            if (in_kind == KIND_INSERT)
            begin
                idx_next = count_reg[ADDR_W-1:0];
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                idx_next = '0;
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
        end
        if (cmd.ext_latch)
        begin
            root_next = ram_rdata0;
            val_next  = ram_rdata1;
        end
        if (cmd.su_step && su_move)
        begin
            idx_next = parent_idx;
        end
        if (cmd.sd_step && sd_move)
        begin
            idx_next = child_idx;
        end
        if (cmd.publish)
        begin
            out_valid_next   = 1'b1;
            out_removed_next = root_reg;
            out_status_next  = status_reg;
            out_count_next   = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            order_mode_reg <= order_mode_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        val_reg         <= val_next;
        root_reg        <= root_next;
        status_reg      <= status_next;
        out_removed_reg <= out_removed_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_removed_value = out_removed_reg;
    assign out_status        = out_status_reg;
    assign out_entry_count   = ENTRY_COUNT_W'(out_count_reg);

endmodule

### rtl/bhpq_checker.sv
`include "binary_heap_priority_queue_macros.svh"

module bhpq_checker import bhpq_pkg::*; (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [VALUE_WIDTH-1:0]   out_removed_value,
    input logic        [STATUS_W-1:0]      out_status,
    input logic        [ENTRY_COUNT_W-1:0] out_entry_count
);

    // A stalled result beat stays offered
    `BHPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

    // The queue is busy on the cycle after it takes a beat
    `BHPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "beat taken on consecutive cycles")

    // A rejected insert reports a full queue
    `BHPQ_ASSERT(a_full_count, out_valid && out_status == ST_FULL |-> out_entry_count == ENTRY_COUNT_W'(CAPACITY), "full status with wrong count")

    // An extract on an empty queue returns nothing and leaves it empty
    `BHPQ_ASSERT(a_empty_result, out_valid && out_status == ST_EMPTY |-> out_entry_count == '0 && out_removed_value == '0, "empty status with stale data")

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_removed_value (out_ch.removed_value),
    .out_status        (out_ch.status),
    .out_entry_count   (out_ch.entry_count)
);

### tb/tb_binary_heap_priority_queue.sv
module tb_binary_heap_priority_queue import bhpq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Ordering register codes
    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = ~VAL_MIN;

    // Give the tail some margin after the worst operation.
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 5;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] removed;
        logic [STATUS_W-1:0]           status;
        logic [ENTRY_COUNT_W-1:0]      count;
    } heap_result_t;

    typedef struct {
        bit                            set_mode;
        logic                          mode;
        logic                          kind;
        logic signed [VALUE_WIDTH-1:0] value;
        bit                            typed;
        heap_result_t                  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    bhpq_in_if  in_ch ();
    bhpq_out_if out_ch ();

    binary_heap_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow heap: same array layout and count as the block keeps.
    logic signed [VALUE_WIDTH-1:0] shadow_heap [CAPACITY];
    int                            shadow_count;
    logic                          shadow_mode;

    heap_result_t pending_results [$];
    stim_row_t    directed_rows [$];
    int           mismatch_count;
    int           idle_cycles;
    bit           send_calm;
    bit           recv_calm;

    // True when a must sit strictly above b under the current ordering.
    function automatic bit outranks(logic signed [VALUE_WIDTH-1:0] a,
                                    logic signed [VALUE_WIDTH-1:0] b);
        return (shadow_mode == MODE_MAX) ? (a > b) : (a < b);
    endfunction

    // Apply one operation to the shadow heap and return the result beat it yields.
    function automatic heap_result_t heap_apply(logic kind, logic signed [VALUE_WIDTH-1:0] value);
        heap_result_t                  res;
        int                            idx;
        int                            parent;
        int                            child;
        int                            last;
        bit                            done;
        logic signed [VALUE_WIDTH-1:0] moving;
        res.removed = '0;
        res.status  = ST_OK;
        if (kind == KIND_INSERT)
        begin
            if (shadow_count >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                // Climb while the parent is strictly worse; equal parents stay put.
                idx  = shadow_count;
                done = 1'b0;
                while (idx > 0 && !done)
                begin
                    parent = (idx - 1) / 2;
                    if (outranks(value, shadow_heap[parent]))
                    begin
                        shadow_heap[idx] = shadow_heap[parent];
                        idx = parent;
                    end
                    else
                        done = 1'b1;
                end
                shadow_heap[idx] = value;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            res.status = ST_EMPTY;
        else
        begin
            res.removed  = shadow_heap[0];
            last         = shadow_count - 1;
            moving       = shadow_heap[last];
            shadow_count = last;
            if (last > 0)
            begin
                // Descend through existing children only; ties go left.
                idx  = 0;
                done = 1'b0;
                while (!done)
                begin
                    child = 2 * idx + 1;
                    if (child >= last)
                        done = 1'b1;
                    else
                    begin
                        if (child + 1 < last && outranks(shadow_heap[child + 1], shadow_heap[child]))
                            child = child + 1;
                        if (outranks(shadow_heap[child], moving))
                        begin
                            shadow_heap[idx] = shadow_heap[child];
                            idx = child;
                        end
                        else
                            done = 1'b1;
                    end
                end
                shadow_heap[idx] = moving;
            end
        end
        res.count = ENTRY_COUNT_W'(shadow_count);
        return res;
    endfunction

    // Mix extremes, a narrow band that forces ties, and full-range values.
    function automatic logic signed [VALUE_WIDTH-1:0] draw_value();
        logic signed [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            1, 2, 3: v = $signed(VALUE_WIDTH'($urandom_range(0, 16))) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic flag_mismatch(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic table_row(bit set_mode, logic mode, logic kind,
                             logic signed [VALUE_WIDTH-1:0] value, bit typed,
                             logic signed [VALUE_WIDTH-1:0] removed,
                             logic [STATUS_W-1:0] status, int count);
        stim_row_t row;
        row.set_mode     = set_mode;
        row.mode         = mode;
        row.kind         = kind;
        row.value        = value;
        row.typed        = typed;
        row.want.removed = removed;
        row.want.status  = status;
        row.want.count   = ENTRY_COUNT_W'(count);
        directed_rows.push_back(row);
    endtask

    // Offer one input beat after a random gap and hold it until taken.
    // Typed expectations override the shadow heap's, which still advances.
    task automatic offer_beat(logic kind, logic signed [VALUE_WIDTH-1:0] value,
                              bit typed, heap_result_t want);
        int           gap;
        heap_result_t predicted;
        if ($urandom_range(0, 31) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = heap_apply(kind, value);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drain every outstanding result, then write the ordering register.
    task automatic settle_and_set_mode(logic mode);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_mode = mode;
    endtask

    // Receiver: random ready gaps, two long hold-offs so the block backs up
    // into its input, and a field-by-field check of every result beat.
    initial
    begin : result_sink
        int           gap;
        int           beats_taken;
        heap_result_t got;
        heap_result_t want;
        out_ch.ready <= 1'b0;
        beats_taken  = 0;
        recv_calm    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                recv_calm = !recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 13);
            if (beats_taken == 60 || beats_taken == 700)
                gap = HOLD_OFF_CYCLES;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            beats_taken++;
            got.removed = out_ch.removed_value;
            got.status  = out_ch.status;
            got.count   = out_ch.entry_count;
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result beat, count", got.count, -1);
            else
            begin
                want = pending_results.pop_front();
                if (got.removed !== want.removed)
                    flag_mismatch("removed_value", got.removed, want.removed);
                if (got.status !== want.status)
                    flag_mismatch("status", got.status, want.status);
                if (got.count !== want.count)
                    flag_mismatch("entry_count", got.count, want.count);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int        phase_items      [NUM_PHASES] = '{300, 250, 150, 160, 390};
        int        phase_insert_pct [NUM_PHASES] = '{85, 25, 100, 0, 55};
        logic      phase_mode       [NUM_PHASES] = '{MODE_MIN, MODE_MAX, MODE_MAX,
                                                     MODE_MIN, MODE_MIN};
        stim_row_t row;
        logic      kind;

        idle_cycles    = 0;
        mismatch_count = 0;
        shadow_count   = 0;
        shadow_mode    = MODE_MIN;
        send_calm      = 1'b0;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= MODE_MIN;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= KIND_INSERT;
        in_ch.value    <= '0;

        // Directed part. Rows with a typed result are the ones plain to see:
        // empty and full-range extremes, and the empty-heap error.
        table_row(1, MODE_MIN, KIND_EXTRACT, '0,       1, '0,      ST_EMPTY, 0);
        table_row(0, MODE_MIN, KIND_INSERT,  VAL_MAX,  1, '0,      ST_OK,    1);
        table_row(0, MODE_MIN, KIND_INSERT,  VAL_MIN,  1, '0,      ST_OK,    2);
        table_row(0, MODE_MIN, KIND_INSERT,  '0,       1, '0,      ST_OK,    3);
        table_row(0, MODE_MIN, KIND_INSERT,  '1,       1, '0,      ST_OK,    4);
        // ties: equal values must not swap past each other
        table_row(0, MODE_MIN, KIND_INSERT,  5,        0, '0,      ST_OK,    0);
        table_row(0, MODE_MIN, KIND_INSERT,  5,        0, '0,      ST_OK,    0);
        table_row(0, MODE_MIN, KIND_INSERT,  5,        0, '0,      ST_OK,    0);
        table_row(0, MODE_MIN, KIND_EXTRACT, '0,       1, VAL_MIN, ST_OK,    6);
        table_row(0, MODE_MIN, KIND_EXTRACT, '0,       0, '0,      ST_OK,    0);
        // flip to max ordering with entries still stored
        table_row(1, MODE_MAX, KIND_INSERT,  3,        0, '0,      ST_OK,    0);
        table_row(0, MODE_MAX, KIND_EXTRACT, 32'hdeadbeef, 0, '0,  ST_OK,    0);
        table_row(0, MODE_MAX, KIND_EXTRACT, '0,       0, '0,      ST_OK,    0);
        table_row(0, MODE_MAX, KIND_EXTRACT, '1,       0, '0,      ST_OK,    0);
        table_row(0, MODE_MAX, KIND_EXTRACT, '0,       0, '0,      ST_OK,    0);
        table_row(0, MODE_MAX, KIND_EXTRACT, VAL_MAX,  0, '0,      ST_OK,    0);
        table_row(0, MODE_MAX, KIND_EXTRACT, '0,       0, '0,      ST_OK,    0);
        table_row(0, MODE_MAX, KIND_EXTRACT, VAL_MIN,  1, '0,      ST_EMPTY, 0);
        table_row(0, MODE_MAX, KIND_INSERT,  VAL_MIN,  1, '0,      ST_OK,    1);
        table_row(0, MODE_MAX, KIND_INSERT,  VAL_MAX,  1, '0,      ST_OK,    2);
        table_row(0, MODE_MAX, KIND_EXTRACT, '0,       1, VAL_MAX, ST_OK,    1);
        table_row(0, MODE_MAX, KIND_EXTRACT, '0,       1, VAL_MIN, ST_OK,    0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.set_mode)
                settle_and_set_mode(row.mode);
            offer_beat(row.kind, row.value, row.typed, row.want);
        end

        // Random phases: fill, drain, push past full, drain past empty, mix.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle_and_set_mode(phase_mode[ph]);
            for (int n = 0; n < phase_items[ph]; n++)
            begin
                kind = ($urandom_range(0, 99) < phase_insert_pct[ph]) ? KIND_INSERT : KIND_EXTRACT;
                offer_beat(kind, draw_value(), 1'b0, '0);
            end
        end

        // Drop valid, wait for the tail, then let any stray beat show up.
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch("results left outstanding", pending_results.size(), 0);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/bhpq_pkg.sv
rtl/bhpq_if.sv
rtl/bhpq_ram.sv
rtl/bhpq_ctrl.sv
rtl/bhpq_dp.sv
rtl/binary_heap_priority_queue.sv
rtl/bhpq_checker.sv
tb/tb_binary_heap_priority_queue.sv
